// ----- rtl/bppf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal position filter package
// Widths, register map, reset values and the control store of the sequencer.
// ----------------------------------------------------------------------------
package bppf_pkg;

  localparam int COEF_W              = 32;
  localparam int MM_W                = 13;
  localparam int PCT_W               = 14;
  localparam int HIST_BITS           = 44;
  localparam int PART_BITS           = 22;
  localparam int FULL_SCALE          = 10000;
  localparam int CFG_IDX_W           = 3;
  localparam int UPC_W               = 5;

  localparam int COEF_FRAC_BITS_DEF  = 28;
  localparam int SAMPLE_BITS_DEF     = 13;

  localparam logic signed [COEF_W-1:0] B0_RST = 32'sd59130;
  localparam logic signed [COEF_W-1:0] B1_RST = 32'sd118260;
  localparam logic signed [COEF_W-1:0] B2_RST = 32'sd59130;
  localparam logic signed [COEF_W-1:0] A1_RST = -32'sd525484685;
  localparam logic signed [COEF_W-1:0] A2_RST = 32'sd257285721;
  localparam logic [MM_W-1:0]          RELEASED_RST = 13'd114;
  localparam logic [MM_W-1:0]          FULL_RST     = 13'd52;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_RELEASED_MM,
    REG_FULL_MM
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MA_B0,
    MA_B1,
    MA_B2,
    MA_A1,
    MA_A2,
    MA_SCALE
  } mul_a_e;

  typedef enum logic [3:0] {
    MB_X,
    MB_X1,
    MB_X2,
    MB_Y1_LO,
    MB_Y1_HI,
    MB_Y2_LO,
    MB_Y2_HI,
    MB_N_LO,
    MB_N_HI
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUBP
  } acc_op_e;

  typedef enum logic [1:0] {
    PACC_NOP,
    PACC_LOAD,
    PACC_ADDHI
  } pacc_op_e;

  typedef enum logic [2:0] {
    MISC_NOP,
    MISC_HIST,
    MISC_MAP,
    MISC_DIV_INIT,
    MISC_DIV_STEP,
    MISC_WRITE
  } misc_op_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_LOOP_DIV,
    SEQ_WAIT_OUT,
    SEQ_RESTART
  } seq_op_e;

  typedef enum logic [UPC_W-1:0] {
    UPC_IDLE,
    UPC_FF0,
    UPC_FF1,
    UPC_FF2,
    UPC_FB1_LO,
    UPC_FB1_HI,
    UPC_FB2_LO,
    UPC_FB2_HI,
    UPC_FB2_ADD,
    UPC_FB2_SUB,
    UPC_HIST,
    UPC_MAP,
    UPC_SCL_LO,
    UPC_SCL_HI,
    UPC_SCL_ADD,
    UPC_DIV_INIT,
    UPC_DIV_STEP,
    UPC_WRITE
  } upc_e;

  typedef struct packed {
    mul_a_e   mul_a;
    mul_b_e   mul_b;
    acc_op_e  acc;
    pacc_op_e pacc;
    misc_op_e misc;
    seq_op_e  seq;
  } ucode_t;

  function automatic ucode_t ucode(input upc_e pc);
    ucode_t w;
    w = '{mul_a: MA_B0, mul_b: MB_X, acc: ACC_NOP, pacc: PACC_NOP,
          misc: MISC_NOP, seq: SEQ_NEXT};
    case (pc)
      UPC_IDLE:     w.seq = SEQ_WAIT_IN;
      UPC_FF0: begin
        w.mul_a = MA_B0;
        w.mul_b = MB_X;
      end
      UPC_FF1: begin
        w.mul_a = MA_B1;
        w.mul_b = MB_X1;
        w.acc   = ACC_LOAD;
      end
      UPC_FF2: begin
        w.mul_a = MA_B2;
        w.mul_b = MB_X2;
        w.acc   = ACC_ADD;
      end
      UPC_FB1_LO: begin
        w.mul_a = MA_A1;
        w.mul_b = MB_Y1_LO;
        w.acc   = ACC_ADD;
      end
      UPC_FB1_HI: begin
        w.mul_a = MA_A1;
        w.mul_b = MB_Y1_HI;
        w.pacc  = PACC_LOAD;
      end
      UPC_FB2_LO: begin
        w.mul_a = MA_A2;
        w.mul_b = MB_Y2_LO;
        w.pacc  = PACC_ADDHI;
      end
      UPC_FB2_HI: begin
        w.mul_a = MA_A2;
        w.mul_b = MB_Y2_HI;
        w.acc   = ACC_SUBP;
        w.pacc  = PACC_LOAD;
      end
      UPC_FB2_ADD:  w.pacc = PACC_ADDHI;
      UPC_FB2_SUB:  w.acc  = ACC_SUBP;
      UPC_HIST:     w.misc = MISC_HIST;
      UPC_MAP:      w.misc = MISC_MAP;
      UPC_SCL_LO: begin
        w.mul_a = MA_SCALE;
        w.mul_b = MB_N_LO;
      end
      UPC_SCL_HI: begin
        w.mul_a = MA_SCALE;
        w.mul_b = MB_N_HI;
        w.pacc  = PACC_LOAD;
      end
      UPC_SCL_ADD:  w.pacc = PACC_ADDHI;
      UPC_DIV_INIT: w.misc = MISC_DIV_INIT;
      UPC_DIV_STEP: begin
        w.misc = MISC_DIV_STEP;
        w.seq  = SEQ_LOOP_DIV;
      end
      UPC_WRITE: begin
        w.misc = MISC_WRITE;
        w.seq  = SEQ_WAIT_OUT;
      end
      default:      w.seq = SEQ_RESTART;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/biquad_pedal_position_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad pedal position filter
// Direct-form-I low-pass on distance samples, mapped to pedal travel.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o | distance_mm_i
//   out     | out       | out_valid_o/out_ready_i | filtered_mm_o,
//           |           |                         | pedal_hundredths_o
//
// A filtered sample runs from one input beat to the next through 16 steps
// of the control store around one shared 32x23 multiplier, 14 steps of the
// radix-2 divider for the travel ratio and one write step. The seeding sample
// after reset only loads the history and gives no beat. A result waits in the
// output register; the sequencer holds in its last step only when a previous
// beat is untaken.
// ----------------------------------------------------------------------------
module biquad_pedal_position_filter
  import bppf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COEF_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] distance_mm_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_mm_o,
  output logic [PCT_W-1:0]       pedal_hundredths_o
);

  localparam int SEED_W  = SAMPLE_BITS + COEF_FRAC_BITS + 1;
  localparam int HIST_W  = (SEED_W > HIST_BITS) ? SEED_W : HIST_BITS;
  localparam int MB_HI_W = HIST_W - PART_BITS;
  localparam int MUL_B_W = (MB_HI_W > PART_BITS + 1) ? MB_HI_W : PART_BITS + 1;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int PACC_W  = COEF_W + HIST_W;
  localparam int FB_W    = COEF_W + HIST_W - COEF_FRAC_BITS;
  localparam int FF_W    = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W   = ((FB_W > FF_W) ? FB_W : FF_W) + 3;
  localparam int RANGE_W = MM_W + COEF_FRAC_BITS;
  localparam int REM_W   = RANGE_W + PCT_W;
  localparam int CNT_W   = $clog2(PCT_W);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - HIST_BITS + 1){1'b0}}, {(HIST_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [HIST_W:0] RND_HALF =
    {{(HIST_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [HIST_W:0] MM_SAT =
    {{(HIST_W + 1 - SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};

  logic signed [COEF_W-1:0]  coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic [MM_W-1:0]           released_q, full_q;

  upc_e                      pc_q, pc_d;
  logic [UPC_W-1:0]          pc_inc;
  logic                      seeded_q, seeded_d;
  logic                      out_valid_q, out_valid_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic [SAMPLE_BITS-1:0]    x_q, x_d, x1_q, x1_d, x2_q, x2_d;
  logic signed [HIST_W-1:0]  y1_q, y1_d, y2_q, y2_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [PACC_W-1:0]  pacc_q, pacc_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [RANGE_W-1:0]        n_q, n_d;
  logic [SAMPLE_BITS-1:0]    mm_q, mm_d;
  logic                      empty_q, empty_d;
  logic [REM_W-1:0]          rem_q, rem_d, dsh_q, dsh_d;
  logic [PCT_W-1:0]          quo_q, quo_d;
  logic [SAMPLE_BITS-1:0]    filt_q, filt_d;
  logic [PCT_W-1:0]          pct_q, pct_d;

  ucode_t                    uw;
  logic                      in_fire, out_free, write_fire;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [HIST_W-1:0]  y1_sh, y2_sh, seed_y;
  logic [RANGE_W-1:0]        n_sh, top_u, bot_u, dprime;
  logic signed [PACC_W-1:0]  pshift;
  logic signed [ACC_W-1:0]   y_sat;
  logic signed [HIST_W:0]    y_ext, y_rnd, mm_sh, top_s, bot_s, yc, n_full;

  assign uw          = ucode(pc_q);
  assign in_ready_o  = (uw.seq == SEQ_WAIT_IN);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign write_fire  = (uw.misc == MISC_WRITE) && out_free;
  assign pc_inc      = pc_q + 1'b1;

  assign out_valid_o        = out_valid_q;
  assign filtered_mm_o      = filt_q;
  assign pedal_hundredths_o = pct_q;

  assign y1_sh  = y1_q >>> PART_BITS;
  assign y2_sh  = y2_q >>> PART_BITS;
  assign n_sh   = n_q >> PART_BITS;
  assign seed_y = HIST_W'(distance_mm_i) << COEF_FRAC_BITS;
  assign pshift = pacc_q >>> COEF_FRAC_BITS;
  assign top_u  = {released_q, {COEF_FRAC_BITS{1'b0}}};
  assign bot_u  = {full_q, {COEF_FRAC_BITS{1'b0}}};
  assign dprime = {released_q - full_q, {COEF_FRAC_BITS{1'b0}}};

  always_comb begin
    case (uw.mul_a)
      MA_B0:    mul_a = coef_b0_q;
      MA_B1:    mul_a = coef_b1_q;
      MA_B2:    mul_a = coef_b2_q;
      MA_A1:    mul_a = coef_a1_q;
      MA_A2:    mul_a = coef_a2_q;
      MA_SCALE: mul_a = COEF_W'(FULL_SCALE);
      default:  mul_a = '0;
    endcase
    case (uw.mul_b)
      MB_X:     mul_b = MUL_B_W'(x_q);
      MB_X1:    mul_b = MUL_B_W'(x1_q);
      MB_X2:    mul_b = MUL_B_W'(x2_q);
      MB_Y1_LO: mul_b = MUL_B_W'(y1_q[PART_BITS-1:0]);
      MB_Y1_HI: mul_b = y1_sh[MUL_B_W-1:0];
      MB_Y2_LO: mul_b = MUL_B_W'(y2_q[PART_BITS-1:0]);
      MB_Y2_HI: mul_b = y2_sh[MUL_B_W-1:0];
      MB_N_LO:  mul_b = MUL_B_W'(n_q[PART_BITS-1:0]);
      MB_N_HI:  mul_b = MUL_B_W'(n_sh);
      default:  mul_b = '0;
    endcase
  end

  always_comb begin
    prod_d = mul_a * mul_b;

    case (uw.pacc)
      PACC_LOAD:  pacc_d = PACC_W'(prod_q);
      PACC_ADDHI: pacc_d = pacc_q + (PACC_W'(prod_q) <<< PART_BITS);
      default:    pacc_d = pacc_q;
    endcase

    case (uw.acc)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      ACC_SUBP: acc_d = acc_q - ACC_W'(pshift);
      default:  acc_d = acc_q;
    endcase

    if (acc_q > SAT_HI) begin
      y_sat = SAT_HI;
    end else if (acc_q < SAT_LO) begin
      y_sat = SAT_LO;
    end else begin
      y_sat = acc_q;
    end

    y_ext = (HIST_W + 1)'(y1_q);
    y_rnd = y_ext + RND_HALF;
    mm_sh = y_rnd >>> COEF_FRAC_BITS;
    top_s = signed'((HIST_W + 1)'(top_u));
    bot_s = signed'((HIST_W + 1)'(bot_u));
    if (y_ext > top_s) begin
      yc = top_s;
    end else if (y_ext < bot_s) begin
      yc = bot_s;
    end else begin
      yc = y_ext;
    end
    n_full = top_s - yc;

    x_d       = x_q;
    x1_d      = x1_q;
    x2_d      = x2_q;
    y1_d      = y1_q;
    y2_d      = y2_q;
    seeded_d  = seeded_q;
    n_d       = n_q;
    mm_d      = mm_q;
    empty_d   = empty_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    filt_d    = filt_q;
    pct_d     = pct_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (in_fire) begin
      x_d = distance_mm_i;
      if (!seeded_q) begin
        x1_d     = distance_mm_i;
        x2_d     = distance_mm_i;
        y1_d     = seed_y;
        y2_d     = seed_y;
        seeded_d = 1'b1;
      end
    end

    case (uw.misc)
      MISC_HIST: begin
        x1_d = x_q;
        x2_d = x1_q;
        y1_d = HIST_W'(y_sat);
        y2_d = y1_q;
      end
      MISC_MAP: begin
        if (mm_sh[HIST_W]) begin
          mm_d = '0;
        end else if (mm_sh > MM_SAT) begin
          mm_d = '1;
        end else begin
          mm_d = mm_sh[SAMPLE_BITS-1:0];
        end
        n_d     = n_full[RANGE_W-1:0];
        empty_d = (full_q >= released_q);
      end
      MISC_DIV_INIT: begin
        rem_d = pacc_q[REM_W-1:0];
        dsh_d = REM_W'(dprime) << (PCT_W - 1);
        quo_d = '0;
        cnt_d = CNT_W'(PCT_W - 1);
      end
      MISC_DIV_STEP: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
          quo_d = {quo_q[PCT_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[PCT_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
      end
      MISC_WRITE: begin
        if (out_free) begin
          filt_d      = mm_q;
          pct_d       = empty_q ? '0 : quo_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    case (uw.seq)
      SEQ_WAIT_IN: begin
        if (in_fire && seeded_q) begin
          pc_d = upc_e'(pc_inc);
        end
      end
      SEQ_NEXT:     pc_d = upc_e'(pc_inc);
      SEQ_LOOP_DIV: begin
        if (cnt_q == '0) begin
          pc_d = upc_e'(pc_inc);
        end
      end
      SEQ_WAIT_OUT: begin
        if (write_fire) begin
          pc_d = UPC_IDLE;
        end
      end
      default:      pc_d = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UPC_IDLE;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      coef_b0_q   <= B0_RST;
      coef_b1_q   <= B1_RST;
      coef_b2_q   <= B2_RST;
      coef_a1_q   <= A1_RST;
      coef_a2_q   <= A2_RST;
      released_q  <= RELEASED_RST;
      full_q      <= FULL_RST;
    end else begin
      pc_q        <= pc_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COEF_B0:     coef_b0_q  <= signed'(cfg_data_i);
          REG_COEF_B1:     coef_b1_q  <= signed'(cfg_data_i);
          REG_COEF_B2:     coef_b2_q  <= signed'(cfg_data_i);
          REG_COEF_A1:     coef_a1_q  <= signed'(cfg_data_i);
          REG_COEF_A2:     coef_a2_q  <= signed'(cfg_data_i);
          REG_RELEASED_MM: released_q <= cfg_data_i[MM_W-1:0];
          REG_FULL_MM:     full_q     <= cfg_data_i[MM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    x1_q    <= x1_d;
    x2_q    <= x2_d;
    y1_q    <= y1_d;
    y2_q    <= y2_d;
    prod_q  <= prod_d;
    pacc_q  <= pacc_d;
    acc_q   <= acc_d;
    n_q     <= n_d;
    mm_q    <= mm_d;
    empty_q <= empty_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    filt_q  <= filt_d;
    pct_q   <= pct_d;
  end

endmodule

// ----- rtl/bppf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal position filter checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module bppf_checker
  import bppf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] filtered_mm_o,
  input logic [PCT_W-1:0]       pedal_hundredths_o
);

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pedal_hundredths_o <= PCT_W'(FULL_SCALE)))
    else $error("pedal travel beyond full scale");

  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(filtered_mm_o) && $stable(pedal_hundredths_o))
    else $error("stalled result beat changed");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && $past(!in_ready_o))
    else $error("result beat not issued from last step");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result beat right after input beat");

endmodule

bind biquad_pedal_position_filter bppf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bppf_checker (.*);

// ----- tb/biquad_pedal_position_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad pedal position filter testbench
// Streams distance samples through the filter under a series of coefficient
// and pedal-range settings, with random gaps and stalls on both channels, and
// compares every result beat with a local model of the biquad and the travel
// mapping or with the values typed into the probe table.
// ----------------------------------------------------------------------------
module biquad_pedal_position_filter_tb;
  import bppf_pkg::*;

  localparam int FRAC          = COEF_FRAC_BITS_DEF;
  localparam int WIDE          = 96;
  localparam int MM_MAX        = (1 << MM_W) - 1;
  localparam int REG_COUNT     = int'(REG_FULL_MM) + 1;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int PRINT_CAP     = 100;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;
  localparam logic [COEF_W-1:0] UNITY_Q  = 1 << FRAC;
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [WIDE-1:0] Y_MAX = (96'sd1 <<< (HIST_BITS - 1)) - 96'sd1;
  localparam logic signed [WIDE-1:0] Y_MIN = -(96'sd1 <<< (HIST_BITS - 1));
  localparam logic signed [WIDE-1:0] HALF_LSB = 96'sd1 <<< (FRAC - 1);

  typedef logic [REG_COUNT-1:0][COEF_W-1:0] reg_file_t;

  typedef struct packed {
    logic [MM_W-1:0]  mm;
    logic [PCT_W-1:0] pct;
  } pedal_beat_t;

  typedef enum int {CHK_PREDICT, CHK_TYPED, CHK_SILENT} row_check_e;
  typedef enum int {
    SET_RESET, SET_PASS, SET_PASS_FLIPPED, SET_PASS_FLAT, SET_RAIL_HIGH, SET_RAIL_LOW
  } preset_e;
  typedef enum int {MIX_LOWPASS, MIX_UNITY, MIX_WILD, MIX_DRIFT} coef_mix_e;

  typedef struct {
    preset_e          preset;
    logic [MM_W-1:0]  sample_mm;
    row_check_e       chk;
    logic [MM_W-1:0]  mm;
    logic [PCT_W-1:0] pct;
  } probe_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COEF_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [MM_W-1:0]      distance_mm_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [MM_W-1:0]      filtered_mm_o;
  logic [PCT_W-1:0]     pedal_hundredths_o;

  biquad_pedal_position_filter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .distance_mm_i      (distance_mm_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .filtered_mm_o      (filtered_mm_o),
    .pedal_hundredths_o (pedal_hundredths_o)
  );

  logic signed [COEF_W-1:0]    k_b0 = B0_RST;
  logic signed [COEF_W-1:0]    k_b1 = B1_RST;
  logic signed [COEF_W-1:0]    k_b2 = B2_RST;
  logic signed [COEF_W-1:0]    k_a1 = A1_RST;
  logic signed [COEF_W-1:0]    k_a2 = A2_RST;
  logic [MM_W-1:0]             rel_cfg  = RELEASED_RST;
  logic [MM_W-1:0]             full_cfg = FULL_RST;
  logic [MM_W-1:0]             x_d1 = '0;
  logic [MM_W-1:0]             x_d2 = '0;
  logic signed [HIST_BITS-1:0] y_d1 = '0;
  logic signed [HIST_BITS-1:0] y_d2 = '0;
  bit                          primed = 1'b0;

  pedal_beat_t pending[$];
  probe_row_t  probes[$];
  reg_file_t   settings_bank [SET_RAIL_LOW+1];
  int          mismatches   = 0;
  int          beats_taken  = 0;
  int          quiet_cycles = 0;
  int          walk_mm      = 0;
  bit          jitter_on    = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] data);
    case (idx)
      REG_COEF_B0:     k_b0 = data;
      REG_COEF_B1:     k_b1 = data;
      REG_COEF_B2:     k_b2 = data;
      REG_COEF_A1:     k_a1 = data;
      REG_COEF_A2:     k_a2 = data;
      REG_RELEASED_MM: rel_cfg = data[MM_W-1:0];
      REG_FULL_MM:     full_cfg = data[MM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit filter_step(input logic [MM_W-1:0] x, output pedal_beat_t r);
    logic signed [WIDE-1:0] xs, x1s, x2s, acc, q, top, bot, yc, pct;
    xs  = WIDE'(x);
    x1s = WIDE'(x_d1);
    x2s = WIDE'(x_d2);
    r   = '0;
    if (!primed) begin
      x_d1   = x;
      x_d2   = x;
      xs     = xs <<< FRAC;
      y_d1   = xs[HIST_BITS-1:0];
      y_d2   = xs[HIST_BITS-1:0];
      primed = 1'b1;
      return 1'b0;
    end
    acc = k_b0 * xs + k_b1 * x1s + k_b2 * x2s
          - ((k_a1 * y_d1) >>> FRAC) - ((k_a2 * y_d2) >>> FRAC);
    if (acc > Y_MAX) acc = Y_MAX;
    if (acc < Y_MIN) acc = Y_MIN;
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = acc[HIST_BITS-1:0];
    q = (acc + HALF_LSB) >>> FRAC;
    if (q < 0) q = 0;
    if (q > MM_MAX) q = MM_MAX;
    if (full_cfg >= rel_cfg) begin
      pct = 0;
    end else begin
      top = WIDE'(rel_cfg);
      top = top <<< FRAC;
      bot = WIDE'(full_cfg);
      bot = bot <<< FRAC;
      yc  = (acc > top) ? top : ((acc < bot) ? bot : acc);
      pct = ((top - yc) * FULL_SCALE) / (top - bot);
    end
    r.mm  = q[MM_W-1:0];
    r.pct = pct[PCT_W-1:0];
    return 1'b1;
  endfunction

  function automatic reg_file_t make_settings(input logic [COEF_W-1:0] b0, b1, b2, a1, a2,
                                              input logic [MM_W-1:0] rel, full);
    reg_file_t v;
    v[REG_COEF_B0]     = b0;
    v[REG_COEF_B1]     = b1;
    v[REG_COEF_B2]     = b2;
    v[REG_COEF_A1]     = a1;
    v[REG_COEF_A2]     = a2;
    v[REG_RELEASED_MM] = COEF_W'(rel);
    v[REG_FULL_MM]     = COEF_W'(full);
    return v;
  endfunction

  function automatic reg_file_t random_settings(input coef_mix_e mix);
    reg_file_t       v;
    int              nudge [5];
    logic [MM_W-1:0] f;
    foreach (nudge[i]) nudge[i] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    v = make_settings(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST, RELEASED_RST, FULL_RST);
    case (mix)
      MIX_UNITY: begin
        v[REG_COEF_B0] = $urandom_range(0, 1 << (FRAC + 1));
        v[REG_COEF_B1] = nudge[1];
        v[REG_COEF_B2] = nudge[2];
        v[REG_COEF_A1] = nudge[3];
        v[REG_COEF_A2] = nudge[4];
      end
      MIX_WILD: begin
        for (int i = 0; i <= int'(REG_COEF_A2); i++) v[i] = $urandom();
      end
      MIX_DRIFT: begin
        v[REG_COEF_B0] = B0_RST + nudge[0];
        v[REG_COEF_B1] = B1_RST + nudge[1];
        v[REG_COEF_B2] = B2_RST + nudge[2];
        v[REG_COEF_A1] = A1_RST + nudge[3] / 16;
        v[REG_COEF_A2] = A2_RST + nudge[4] / 16;
      end
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: begin
        v[REG_RELEASED_MM] = MM_MAX;
        v[REG_FULL_MM]     = '0;
      end
      1: begin
        v[REG_RELEASED_MM] = $urandom_range(0, MM_MAX);
        v[REG_FULL_MM]     = $urandom_range(0, MM_MAX);
      end
      2: ;
      default: begin
        f = MM_W'($urandom_range(0, 4000));
        v[REG_FULL_MM]     = COEF_W'(f);
        v[REG_RELEASED_MM] = COEF_W'(f) + $urandom_range(1, 4191);
      end
    endcase
    return v;
  endfunction

  function automatic logic [MM_W-1:0] next_distance();
    int lo, hi;
    lo = (full_cfg < rel_cfg) ? int'(full_cfg) : int'(rel_cfg);
    hi = (full_cfg < rel_cfg) ? int'(rel_cfg) : int'(full_cfg);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MM_W'(MM_MAX);
      2, 3:    return MM_W'($urandom_range(0, MM_MAX));
      4:       return MM_W'($urandom_range(lo, hi));
      default: begin
        walk_mm += int'($urandom_range(0, 60)) - 30;
        if (walk_mm < 0) walk_mm = 0;
        if (walk_mm > MM_MAX) walk_mm = MM_MAX;
        return MM_W'(walk_mm);
      end
    endcase
  endfunction

  function automatic void add_probe(input preset_e preset, input int sample_mm,
                                    input row_check_e chk, input int mm, input int pct);
    probe_row_t row;
    row.preset    = preset;
    row.sample_mm = MM_W'(sample_mm);
    row.chk       = chk;
    row.mm        = MM_W'(mm);
    row.pct       = PCT_W'(pct);
    probes.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: %s", $time, msg);
  endtask

  task automatic put_sample(input logic [MM_W-1:0] sample_mm, input row_check_e chk,
                            input logic [MM_W-1:0] mm, input logic [PCT_W-1:0] pct);
    pedal_beat_t beat;
    bit          fresh;
    in_valid_i    <= 1'b1;
    distance_mm_i <= sample_mm;
    do @(posedge clk_i); while (!in_ready_o);
    fresh = filter_step(sample_mm, beat);
    if (fresh && chk != CHK_SILENT) begin
      if (chk == CHK_TYPED) begin
        beat.mm  = mm;
        beat.pct = pct;
      end
      pending.push_back(beat);
    end
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic apply_settings(input reg_file_t v);
    logic [COEF_W-1:0] junk;
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= v[i];
      set_register(cfg_reg_e'(i), v[i]);
      @(posedge clk_i);
    end
    junk = $urandom();
    cfg_index_i <= REG_NONE;
    cfg_data_i  <= junk;
    set_register(REG_NONE, junk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (jitter_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pedal_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing pending: mm %0d pct %0d",
                                  beats_taken, filtered_mm_o, pedal_hundredths_o));
      end else begin
        want = pending.pop_front();
        if (filtered_mm_o !== want.mm)
          report_mismatch($sformatf("beat %0d filtered_mm: got %0d, want %0d",
                                    beats_taken, filtered_mm_o, want.mm));
        if (pedal_hundredths_o !== want.pct)
          report_mismatch($sformatf("beat %0d pedal_hundredths: got %0d, want %0d",
                                    beats_taken, pedal_hundredths_o, want.pct));
      end
      beats_taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    preset_e cur_set;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_COEF_B0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    distance_mm_i <= '0;

    settings_bank[SET_RESET] = make_settings(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST,
                                             RELEASED_RST, FULL_RST);
    settings_bank[SET_PASS] = make_settings(UNITY_Q, '0, '0, '0, '0, RELEASED_RST, FULL_RST);
    settings_bank[SET_PASS_FLIPPED] = make_settings(UNITY_Q, '0, '0, '0, '0,
                                                    FULL_RST, RELEASED_RST);
    settings_bank[SET_PASS_FLAT] = make_settings(UNITY_Q, '0, '0, '0, '0, 13'd100, 13'd100);
    settings_bank[SET_RAIL_HIGH] = make_settings(COEF_MAX, COEF_MAX, COEF_MAX,
                                                 COEF_MIN, COEF_MIN, MM_MAX, '0);
    settings_bank[SET_RAIL_LOW] = make_settings(COEF_MIN, COEF_MIN, COEF_MIN,
                                                COEF_MAX, '0, MM_MAX, '0);

    // preset         distance check        mm    pct
    add_probe(SET_RESET,        MM_MAX, CHK_SILENT,  0,    0);
    add_probe(SET_RESET,        0,      CHK_PREDICT, 0,    0);
    add_probe(SET_RESET,        MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RESET,        114,    CHK_PREDICT, 0,    0);
    add_probe(SET_RESET,        52,     CHK_PREDICT, 0,    0);
    add_probe(SET_RESET,        4096,   CHK_PREDICT, 0,    0);
    add_probe(SET_PASS,         114,    CHK_TYPED,   114,  0);
    add_probe(SET_PASS,         52,     CHK_TYPED,   52,   10000);
    add_probe(SET_PASS,         0,      CHK_TYPED,   0,    10000);
    add_probe(SET_PASS,         MM_MAX, CHK_TYPED,   MM_MAX, 0);
    add_probe(SET_PASS,         83,     CHK_TYPED,   83,   5000);
    add_probe(SET_PASS,         53,     CHK_TYPED,   53,   9838);
    add_probe(SET_PASS,         113,    CHK_TYPED,   113,  161);
    add_probe(SET_PASS_FLIPPED, 60,     CHK_TYPED,   60,   0);
    add_probe(SET_PASS_FLIPPED, MM_MAX, CHK_TYPED,   MM_MAX, 0);
    add_probe(SET_PASS_FLAT,    100,    CHK_TYPED,   100,  0);
    add_probe(SET_PASS_FLAT,    0,      CHK_TYPED,   0,    0);
    add_probe(SET_RAIL_HIGH,    MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_HIGH,    MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_HIGH,    0,      CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_HIGH,    MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_LOW,     MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_LOW,     MM_MAX, CHK_PREDICT, 0,    0);
    add_probe(SET_RAIL_LOW,     0,      CHK_PREDICT, 0,    0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_set = SET_RESET;
    foreach (probes[i]) begin
      if (probes[i].preset != cur_set) begin
        cur_set = probes[i].preset;
        apply_settings(settings_bank[cur_set]);
      end
      put_sample(probes[i].sample_mm, probes[i].chk, probes[i].mm, probes[i].pct);
    end

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(random_settings(coef_mix_e'(p % 4)));
      jitter_on = (p != PHASES - 1);
      if (p == 0) hold_req = 1'b1;
      walk_mm = (int'(full_cfg) + int'(rel_cfg)) / 2;
      for (int n = 0; n < PHASE_ITEMS; n++) put_sample(next_distance(), CHK_PREDICT, '0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bppf_pkg.sv
rtl/biquad_pedal_position_filter.sv
rtl/bppf_checker.sv
tb/biquad_pedal_position_filter_tb.sv
